[design/spm_pkg.sv]
// ---------------------------------------------------------------------------
// spm_pkg: shared types and constants of the polynomial multiplier
// Request formats of both channels, field widths and the control group
// that the sequencer hands to every cell of the chain.
// ---------------------------------------------------------------------------
package spm_pkg;

	localparam int COEF_W        = 16;
	localparam int ACC_W         = 37;
	localparam int DEG_W         = 6;
	localparam int MAX_TERMS_DEF = 32;
	localparam int COEF_BITS_DEF = 16;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic                     last_term;
	} in_req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] product_coef;
		logic [DEG_W-1:0]        degree_index;
		logic                    last_result;
	} out_req_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic step;
	} cell_ctl_t;

endpackage

[design/schoolbook_polynomial_multiply.sv]
// ---------------------------------------------------------------------------
// schoolbook_polynomial_multiply: full product of two coefficient streams
// Pairs are loaded into a chain of MAX_TERMS cells; the last pair starts a
// transposed convolution that streams the 2n-1 product coefficients out.
//
//   channel | signals                       | request
//   --------+-------------------------------+---------------------------------
//   input   | in_valid, in_stall, in_item   | coef_a, coef_b, last_term
//   output  | out_valid, out_stall, out_item| product_coef, degree_index, last
//
// A pair is taken whenever no job runs. After the last pair the chain runs 2n+1
// steps for n pairs, one step per cycle while no held output is stalled,
// and the coefficients leave one per cycle from the third step on: the
// 2n-1 product coefficients follow the two-step lag of the chain.
// in_stall is high while a job runs. out_stall freezes the whole chain
// while out_valid is high. Reset clears the sequencer only.
// ---------------------------------------------------------------------------
module schoolbook_polynomial_multiply #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF,
	parameter int COEF_BITS = spm_pkg::COEF_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  spm_pkg::in_req_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output spm_pkg::out_req_t out_item
);

	localparam int CW    = (COEF_BITS < spm_pkg::COEF_W) ? COEF_BITS : spm_pkg::COEF_W;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int T_W   = CNT_W + 1;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   n_q;
	logic [T_W-1:0]     t_q;
	logic [T_W-1:0]     deg_full;
	logic               busy_q;
	logic               out_valid_q;
	spm_pkg::out_req_t  out_q;

	logic               accept;
	logic               full;
	logic               step;
	spm_pkg::cell_ctl_t ctl;
	logic signed [CW-1:0] x;

	logic signed [CW-1:0]             a_chain [0:MAX_TERMS];
	logic signed [spm_pkg::ACC_W-1:0] s_chain [0:MAX_TERMS];

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign full     = cnt_q == CNT_W'(MAX_TERMS);
	assign step     = busy_q && (!out_valid_q || !out_stall);

	assign ctl = '{
		load:  accept && !full,
		clear: accept && in_item.last_term,
		step:  step
	};

	// Past the last pair, zeros are fed so that the tail of the product drains.
	assign x = (t_q < {1'b0, n_q}) ? a_chain[0] : '0;

	assign a_chain[MAX_TERMS] = '0;
	assign s_chain[MAX_TERMS] = '0;

	for (genvar j = 0; j < MAX_TERMS; j++) begin : g_cell
		spm_cell #(
			.IDX   (j),
			.CW    (CW),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_idx  (cnt_q),
			.n_terms (n_q),
			.wr_a    (in_item.coef_a[CW-1:0]),
			.wr_b    (in_item.coef_b[CW-1:0]),
			.x       (x),
			.a_in    (a_chain[j+1]),
			.s_in    (s_chain[j+1]),
			.a_out   (a_chain[j]),
			.s_out   (s_chain[j])
		);
	end

	assign deg_full = t_q - T_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			n_q         <= '0;
			t_q         <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (in_item.last_term) begin
					cnt_q  <= '0;
					n_q    <= full ? cnt_q : cnt_q + CNT_W'(1);
					t_q    <= '0;
					busy_q <= 1'b1;
				end else if (!full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (step) begin
				t_q <= t_q + T_W'(1);
				if (t_q == {n_q, 1'b0}) begin
					busy_q <= 1'b0;
				end
			end
			// The chain output lags the step count by two steps.
			if (step && t_q >= T_W'(2)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && t_q >= T_W'(2)) begin
			out_q.product_coef <= s_chain[0];
			out_q.degree_index <= spm_pkg::DEG_W'(deg_full);
			out_q.last_result  <= t_q == {n_q, 1'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[design/spm_cell.sv]
// ---------------------------------------------------------------------------
// spm_cell: one tap of the convolution chain
// Holds one coefficient of each polynomial. While a job runs, the a
// coefficient moves one cell down per step, and the cell adds b times the
// broadcast a coefficient into the partial sum passed down the chain.
// ---------------------------------------------------------------------------
module spm_cell #(
	parameter int IDX   = 0,
	parameter int CW    = 16,
	parameter int CNT_W = 6
) (
	input  logic                           clk,
	input  spm_pkg::cell_ctl_t             ctl,
	input  logic [CNT_W-1:0]               wr_idx,
	input  logic [CNT_W-1:0]               n_terms,
	input  logic signed [CW-1:0]           wr_a,
	input  logic signed [CW-1:0]           wr_b,
	input  logic signed [CW-1:0]           x,
	input  logic signed [CW-1:0]           a_in,
	input  logic signed [spm_pkg::ACC_W-1:0] s_in,
	output logic signed [CW-1:0]           a_out,
	output logic signed [spm_pkg::ACC_W-1:0] s_out
);

	logic signed [CW-1:0]             a_q;
	logic signed [CW-1:0]             b_q;
	logic signed [spm_pkg::ACC_W-1:0] p_q;
	logic signed [spm_pkg::ACC_W-1:0] s_q;
	logic signed [2*CW-1:0]           prod;
	logic                             active;

	// Cells beyond the job's length still hold coefficients of an older job.
	assign active = CNT_W'(IDX) < n_terms;
	assign prod   = x * b_q;

	always_ff @(posedge clk) begin
		if (ctl.load && wr_idx == CNT_W'(IDX)) begin
			a_q <= wr_a;
			b_q <= wr_b;
		end else if (ctl.step) begin
			a_q <= a_in;
		end
		if (ctl.clear) begin
			p_q <= '0;
			s_q <= '0;
		end else if (ctl.step) begin
			p_q <= active ? spm_pkg::ACC_W'(prod) : '0;
			s_q <= s_in + p_q;
		end
	end

	assign a_out = a_q;
	assign s_out = s_q;

endmodule

[tb/schoolbook_polynomial_multiply_tb.sv]
// ---------------------------------------------------------------------------
// schoolbook_polynomial_multiply_tb: self-checking bench for the multiplier
// Streams coefficient pairs into the block and predicts every job's product
// by direct convolution. Each product coefficient that leaves the block is
// compared against the oldest prediction. Runs cover directed extremes, an
// overfull store, a drain pause and random jobs under three stall mixes.
// ---------------------------------------------------------------------------
module schoolbook_polynomial_multiply_tb;

	localparam int MAX_TERMS   = spm_pkg::MAX_TERMS_DEF;
	localparam int COEF_BITS   = spm_pkg::COEF_BITS_DEF;
	localparam int PROD_LEN    = 2 * MAX_TERMS - 1;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 3 * MAX_TERMS + 16;
	localparam int REPORT_MAX  = 10;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	spm_pkg::in_req_t  in_item   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	spm_pkg::out_req_t out_item;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	logic [spm_pkg::COEF_W-1:0] held_a [MAX_TERMS];
	logic [spm_pkg::COEF_W-1:0] held_b [MAX_TERMS];
	int                         held_count = 0;
	spm_pkg::out_req_t          expected_coefs [$];

	int error_count   = 0;
	int pairs_sent    = 0;
	int jobs_done     = 0;
	int coefs_checked = 0;
	int idle_cycles   = 0;

	schoolbook_polynomial_multiply #(
		.MAX_TERMS(MAX_TERMS),
		.COEF_BITS(COEF_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Keeps the low COEF_BITS bits of a stored coefficient as a signed value.
	function automatic longint coef_val(logic [spm_pkg::COEF_W-1:0] raw);
		longint v;
		v = longint'($signed(raw));
		if (COEF_BITS < spm_pkg::COEF_W) begin
			v = (v << (64 - COEF_BITS)) >>> (64 - COEF_BITS);
		end
		return v;
	endfunction

	function automatic void convolve_job(int n);
		logic [spm_pkg::ACC_W-1:0] sums [PROD_LEN];
		spm_pkg::out_req_t         coef;
		for (int k = 0; k < PROD_LEN; k++) sums[k] = '0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				sums[i+j] = sums[i+j]
					+ spm_pkg::ACC_W'(coef_val(held_a[i]) * coef_val(held_b[j]));
			end
		end
		for (int k = 0; k < 2 * n - 1; k++) begin
			coef.product_coef = sums[k];
			coef.degree_index = spm_pkg::DEG_W'(k);
			coef.last_result  = (k == 2 * n - 2);
			expected_coefs.push_back(coef);
		end
	endfunction

	function automatic void absorb_pair(spm_pkg::in_req_t req);
		// Pairs beyond the store size are dropped, but a dropped last pair
		// still closes the job.
		if (held_count < MAX_TERMS) begin
			held_a[held_count] = req.coef_a;
			held_b[held_count] = req.coef_b;
			held_count++;
		end
		pairs_sent++;
		if (req.last_term) begin
			convolve_job(held_count);
			held_count = 0;
			jobs_done++;
		end
	endfunction

	function automatic void report_error(string msg);
		error_count++;
		if (error_count <= REPORT_MAX) $display("ERROR: %s", msg);
	endfunction

	function automatic void check_coef(spm_pkg::out_req_t got);
		spm_pkg::out_req_t want;
		if (expected_coefs.size() == 0) begin
			report_error($sformatf("unexpected coefficient %0d at degree %0d",
				got.product_coef, got.degree_index));
			return;
		end
		want = expected_coefs.pop_front();
		coefs_checked++;
		if (got !== want) begin
			report_error($sformatf(
				"expected coef %0d deg %0d last %0b, got coef %0d deg %0d last %0b",
				want.product_coef, want.degree_index, want.last_result,
				got.product_coef, got.degree_index, got.last_result));
		end
	endfunction

	// Input side is handled before output side so that the prediction for
	// a job exists before any of its coefficients can be compared.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) absorb_pair(in_item);
			if (out_valid && !out_stall) check_coef(out_item);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_pair(input logic [spm_pkg::COEF_W-1:0] a,
			input logic [spm_pkg::COEF_W-1:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item  <= '{coef_a: a, coef_b: b, last_term: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic [spm_pkg::COEF_W-1:0] rand_coef();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return spm_pkg::COEF_W'($urandom);
		endcase
	endfunction

	task automatic send_job(int n);
		for (int i = 0; i < n; i++) send_pair(rand_coef(), rand_coef(), i == n - 1);
	endtask

	task automatic test_directed();
		// Short jobs of one to three terms, mostly at the corners of the signed range.
		send_pair(16'h8000, 16'h8000, 1'b1);
		send_pair(16'h7fff, 16'h8000, 1'b1);
		send_pair(16'h7fff, 16'h7fff, 1'b0);
		send_pair(16'h8000, 16'h8000, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'hffff, 16'h0001, 1'b0);
		send_pair(16'h3039, 16'hcfc7, 1'b1);
		// All-negative-extreme operands give the largest coefficient sums.
		for (int i = 0; i < 4; i++) send_pair(16'h8000, 16'h8000, i == 3);
		for (int i = 0; i < 4; i++) begin
			send_pair(i[0] ? 16'h8000 : 16'h7fff, i[0] ? 16'h7fff : 16'h8000, i == 3);
		end
	endtask

	task automatic test_random_jobs(int budget);
		int sent;
		int n;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0) n = $urandom_range(7, MAX_TERMS);
			else n = $urandom_range(1, 6);
			send_job(n);
			sent += n;
		end
	endtask

	task automatic test_store_overflow();
		// Two pairs past a full store: the first dropped without the last
		// flag, the second dropped while carrying it.
		send_job(MAX_TERMS + 2);
	endtask

	task automatic test_drain_pause();
		send_job($urandom_range(2, 8));
		stop_sending();
		while (expected_coefs.size() != 0) @(negedge clk);
		send_job($urandom_range(1, 4));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		sender_idle_pct    = 19;
		receiver_stall_pct = 59;
		test_directed();
		test_random_jobs(35);

		sender_idle_pct    = 59;
		receiver_stall_pct = 19;
		test_store_overflow();
		test_drain_pause();
		test_random_jobs(35);

		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		test_random_jobs(35);

		stop_sending();
		while (expected_coefs.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_coefs.size() != 0) begin
			report_error($sformatf("%0d coefficients never arrived", expected_coefs.size()));
		end

		$display("covered %0d pairs in %0d jobs, %0d product coefficients checked",
			pairs_sent, jobs_done, coefs_checked);
		$display("included corner operands, an overfull store, a drain pause, %0d errors",
			error_count);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
